// ===== rtl/json_string_escaper_defines.svh =====
// Assertion helpers for the JSON string escaper.
// Each check is sampled on the rising edge of clk and is off while rst_n is low.
`ifndef JSON_STRING_ESCAPER_DEFINES_SVH
`define JSON_STRING_ESCAPER_DEFINES_SVH

// Same-cycle implication.
`define JSESC_CHECK_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define JSESC_CHECK_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/jsesc_pkg.sv =====
`default_nettype none

package jsesc_pkg;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_U      = 8'h75;

    // Character positions inside one \uxxxx escape
    localparam logic [2:0] DIG_BSLASH = 3'd0;
    localparam logic [2:0] DIG_U      = 3'd1;
    localparam logic [2:0] DIG_N3     = 3'd2;
    localparam logic [2:0] DIG_N2     = 3'd3;
    localparam logic [2:0] DIG_N1     = 3'd4;
    localparam logic [2:0] DIG_N0     = 3'd5;

    // Everything one item expands to, in output order:
    // opening quote, \uxxxx escapes, plain or two-char escape, closing quote.
    typedef struct packed {
        logic             open;
        logic [2:0]       hex_cnt;
        logic [3:0][15:0] hex;
        logic [1:0]       chr_cnt;
        logic [1:0][7:0]  chr;
        logic             close;
    } jsesc_job_t;

    typedef struct packed {
        logic [1:0] pend_cnt;
        logic [1:0] need_cnt;
    } jsesc_front_stat_t;

    function automatic logic job_busy(input jsesc_job_t j);
        return j.open || j.close || (j.hex_cnt != 3'd0) || (j.chr_cnt != 2'd0);
    endfunction

    function automatic logic [7:0] hex_digit(input logic [3:0] nib);
        if (nib < 4'd10)
        begin
            return 8'h30 + {4'h0, nib};
        end
        return 8'h57 + {4'h0, nib};
    endfunction

    // {hit, letter} for bytes with a two-character escape
    function automatic logic [8:0] esc_letter(input logic [7:0] c);
        case (c)
            8'h22:   return {1'b1, 8'h22};
            8'h5C:   return {1'b1, 8'h5C};
            8'h08:   return {1'b1, 8'h62};
            8'h0C:   return {1'b1, 8'h66};
            8'h0A:   return {1'b1, 8'h6E};
            8'h0D:   return {1'b1, 8'h72};
            8'h09:   return {1'b1, 8'h74};
            default: return 9'h000;
        endcase
    endfunction

    function automatic logic [7:0] lead_mask(input logic [1:0] need);
        case (need)
            2'd1:    return 8'h1F;
            2'd2:    return 8'h0F;
            2'd3:    return 8'h07;
            default: return 8'h7F;
        endcase
    endfunction

endpackage

`default_nettype wire

// ===== rtl/jsesc_front.sv =====
`default_nettype none

module jsesc_front
    import jsesc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              escape_utf8,
    input  wire logic              accept,
    input  wire logic [7:0]        in_byte,
    input  wire logic              has_byte,
    input  wire logic              first_of_string,
    input  wire logic              last_of_string,
    output jsesc_job_t             job,
    output logic                   job_nonempty,
    output jsesc_front_stat_t      stat
);

    logic [1:0] pend_cnt_reg, pend_cnt_next;
    logic [1:0] need_cnt_reg, need_cnt_next;
    logic [7:0] pend_bytes_reg [0:2];

    logic       pb_we;
    logic [1:0] pb_widx;
    logic [2:0] hc;
    logic       do_fresh;
    logic [8:0] esc;
    logic [1:0] need;
    logic [7:0] lead_m;
    logic [20:0] cp;
    logic [20:0] v;
    logic [7:0] view_byte;
    jsesc_job_t j;

    // Code point of a sequence that the current byte completes
    always_comb
    begin
        lead_m = pend_bytes_reg[0] & lead_mask(need_cnt_reg);
        case (pend_cnt_reg)
            2'd1:    cp = {7'h00, lead_m, in_byte[5:0]};
            2'd2:    cp = {1'b0, lead_m, pend_bytes_reg[1][5:0], in_byte[5:0]};
            2'd3:    cp = {lead_m[2:0], pend_bytes_reg[1][5:0], pend_bytes_reg[2][5:0],
                           in_byte[5:0]};
            default: cp = 21'h0;
        endcase
        v = cp - 21'h010000;
    end

    assign esc = esc_letter(in_byte);

    always_comb
    begin
        j             = '0;
        hc            = 3'd0;
        pb_we         = 1'b0;
        pb_widx       = 2'd0;
        need          = 2'd0;
        do_fresh      = 1'b0;
        view_byte     = 8'h00;
        pend_cnt_next = pend_cnt_reg;
        need_cnt_next = need_cnt_reg;

        if (first_of_string)
        begin
            j.open        = 1'b1;
            pend_cnt_next = 2'd0;
            need_cnt_next = 2'd0;
        end

        if (has_byte)
        begin
            if (pend_cnt_next == 2'd0)
            begin
                do_fresh = 1'b1;
            end
            else if (in_byte[7:6] == 2'b10)
            begin
                if (pend_cnt_next >= need_cnt_next)
                begin
                    if (cp[20:16] == 5'd0)
                    begin
                        j.hex[0] = cp[15:0];
                        hc       = 3'd1;
                    end
                    else
                    begin
                        j.hex[0] = 16'hD800 + {5'h00, v[20:10]};
                        j.hex[1] = 16'hDC00 | {6'h00, v[9:0]};
                        hc       = 3'd2;
                    end
                    pend_cnt_next = 2'd0;
                    need_cnt_next = 2'd0;
                end
                else
                begin
                    pb_we         = 1'b1;
                    pb_widx       = pend_cnt_next;
                    pend_cnt_next = pend_cnt_next + 2'd1;
                end
            end
            else
            begin
                // Broken sequence: escape what was held, then treat byte as new
                for (int k = 0; k < 3; k++)
                begin
                    if (2'(k) < pend_cnt_next)
                    begin
                        j.hex[hc[1:0]] = {8'h00, pend_bytes_reg[2'(k)]};
                        hc             = hc + 3'd1;
                    end
                end
                pend_cnt_next = 2'd0;
                need_cnt_next = 2'd0;
                do_fresh      = 1'b1;
            end
        end

        if (do_fresh)
        begin
            if (esc[8])
            begin
                j.chr_cnt = 2'd2;
                j.chr[0]  = CH_BSLASH;
                j.chr[1]  = esc[7:0];
            end
            else if (in_byte < 8'h20)
            begin
                j.hex[hc[1:0]] = {8'h00, in_byte};
                hc             = hc + 3'd1;
            end
            else if (escape_utf8 && in_byte[7])
            begin
                if (in_byte[7:5] == 3'b110)
                begin
                    need = 2'd1;
                end
                else if (in_byte[7:4] == 4'b1110)
                begin
                    need = 2'd2;
                end
                else if (in_byte[7:3] == 5'b11110)
                begin
                    need = 2'd3;
                end
                if (need == 2'd0)
                begin
                    j.hex[hc[1:0]] = {8'h00, in_byte};
                    hc             = hc + 3'd1;
                end
                else
                begin
                    pb_we         = 1'b1;
                    pb_widx       = 2'd0;
                    pend_cnt_next = 2'd1;
                    need_cnt_next = need;
                end
            end
            else
            begin
                j.chr_cnt = 2'd1;
                j.chr[0]  = in_byte;
            end
        end

        if (last_of_string)
        begin
            // Flush whatever is held, including a byte stored by this item
            for (int k = 0; k < 3; k++)
            begin
                if (2'(k) < pend_cnt_next)
                begin
                    view_byte = (pb_we && (pb_widx == 2'(k))) ? in_byte
                                                              : pend_bytes_reg[2'(k)];
                    j.hex[hc[1:0]] = {8'h00, view_byte};
                    hc             = hc + 3'd1;
                end
            end
            pend_cnt_next = 2'd0;
            need_cnt_next = 2'd0;
            j.close       = 1'b1;
        end

        j.hex_cnt = hc;
    end

    assign job           = j;
    assign job_nonempty  = job_busy(j);
    assign stat.pend_cnt = pend_cnt_reg;
    assign stat.need_cnt = need_cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_cnt_reg <= 2'd0;
            need_cnt_reg <= 2'd0;
        end
        else if (accept)
        begin
            pend_cnt_reg <= pend_cnt_next;
            need_cnt_reg <= need_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && pb_we)
        begin
            pend_bytes_reg[pb_widx] <= in_byte;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/jsesc_queue.sv =====
`default_nettype none

module jsesc_queue
    import jsesc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    input  wire jsesc_job_t  push_job,
    input  wire logic        pop,
    output logic             head_valid,
    output jsesc_job_t       head_job,
    output logic             full,
    output logic [1:0]       count
);

    jsesc_job_t slot_reg [0:1];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign head_valid = (count_reg != 2'd0);
    assign head_job   = slot_reg[rd_ptr_reg];
    assign full       = (count_reg == 2'd2);
    assign count      = count_reg;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/jsesc_back.sv =====
`default_nettype none

module jsesc_back
    import jsesc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        head_valid,
    input  wire jsesc_job_t  head_job,
    output logic             pop,
    output logic             out_valid,
    output logic [7:0]       out_char,
    output logic             end_of_run,
    input  wire logic        out_stall
);

    jsesc_job_t cur_reg, cur_next;
    logic [2:0] digit_reg, digit_next;
    logic       out_valid_reg;
    logic [7:0] out_char_reg;
    logic       end_reg;

    jsesc_job_t work;
    logic       busy;
    logic       avail;
    logic       adv;
    logic       step;
    logic [7:0] ch;
    logic       last;

    assign busy  = job_busy(cur_reg);
    assign work  = busy ? cur_reg : head_job;
    assign avail = busy || head_valid;
    assign adv   = !out_valid_reg || !out_stall;
    assign step  = adv && avail;
    assign pop   = step && !busy;

    // Emit the first thing still owed by the job, retire it
    always_comb
    begin
        cur_next   = work;
        digit_next = digit_reg;
        ch         = CH_QUOTE;
        if (work.open)
        begin
            cur_next.open = 1'b0;
        end
        else if (work.hex_cnt != 3'd0)
        begin
            case (digit_reg)
                DIG_BSLASH: ch = CH_BSLASH;
                DIG_U:      ch = CH_U;
                DIG_N3:     ch = hex_digit(work.hex[0][15:12]);
                DIG_N2:     ch = hex_digit(work.hex[0][11:8]);
                DIG_N1:     ch = hex_digit(work.hex[0][7:4]);
                DIG_N0:     ch = hex_digit(work.hex[0][3:0]);
                default:    ch = CH_BSLASH;
            endcase
            if (digit_reg == DIG_N0)
            begin
                cur_next.hex     = {16'h0000, work.hex[3:1]};
                cur_next.hex_cnt = work.hex_cnt - 3'd1;
                digit_next       = DIG_BSLASH;
            end
            else
            begin
                digit_next = digit_reg + 3'd1;
            end
        end
        else if (work.chr_cnt != 2'd0)
        begin
            ch               = work.chr[0];
            cur_next.chr     = {8'h00, work.chr[1]};
            cur_next.chr_cnt = work.chr_cnt - 2'd1;
        end
        else
        begin
            cur_next.close = 1'b0;
        end
        last = !job_busy(cur_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg       <= '0;
            digit_reg     <= DIG_BSLASH;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (step)
            begin
                cur_reg   <= cur_next;
                digit_reg <= digit_next;
            end
            if (adv)
            begin
                out_valid_reg <= avail;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_char_reg <= ch;
            end_reg      <= last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_char   = out_char_reg;
    assign end_of_run = end_reg;

endmodule

`default_nettype wire

// ===== rtl/json_string_escaper.sv =====
// Streaming JSON string escaper.
// Input channel (in_valid / in_stall): one item per handshake, carrying at most one
// string byte plus first_of_string and last_of_string marks. Output channel
// (out_valid / out_stall): one character of the quoted, escaped string per item
// moved; end_of_run marks the last character caused by an input item. An item that
// only buffers a UTF-8 lead or continuation byte causes no characters at all.
// Config (cfg_valid / cfg_ready / cfg_data): the UTF-8 escape mode, always ready;
// write it only while no characters are outstanding.
// Path: an accepted item is written into a queue slot; its first character is then
// registered in the output register. Characters per item: one for plain ASCII, two
// for a short escape, six per \uxxxx, up to 25 for four flushed escapes of a broken
// sequence plus the closing quote. The back end has a single output register; the
// two-entry queue between front and back lets plain text stream at one item per
// cycle while out_stall stays low.
// Reset: clears the queue, the UTF-8 buffer state, the back end's job and output
// valid flag, and turns the escape mode off. A stalled receiver holds the output
// item; in_stall rises once the queue is full.
`default_nettype none

`include "json_string_escaper_defines.svh"

module json_string_escaper
    import jsesc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_data,

    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  in_byte,
    input  wire logic        has_byte,
    input  wire logic        first_of_string,
    input  wire logic        last_of_string,

    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [7:0]       out_char,
    output logic             end_of_run
);

    logic              escape_utf8_reg;
    logic              in_accept;
    jsesc_job_t        front_job;
    logic              front_nonempty;
    jsesc_front_stat_t front_stat;
    logic              q_push;
    logic              q_pop;
    logic              q_head_valid;
    jsesc_job_t        q_head_job;
    logic              q_full;
    logic [1:0]        q_count;

    // Config register: always ready, take the write on the handshake
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            escape_utf8_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            escape_utf8_reg <= cfg_data;
        end
    end

    // Hold the input whenever the queue cannot take another job
    assign in_stall  = q_full;
    assign in_accept = in_valid && !in_stall;
    // Drop items that expand to nothing; they only update the UTF-8 buffer
    assign q_push    = in_accept && front_nonempty;

    jsesc_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .escape_utf8     (escape_utf8_reg),
        .accept          (in_accept),
        .in_byte         (in_byte),
        .has_byte        (has_byte),
        .first_of_string (first_of_string),
        .last_of_string  (last_of_string),
        .job             (front_job),
        .job_nonempty    (front_nonempty),
        .stat            (front_stat)
    );

    jsesc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_job   (front_job),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_job   (q_head_job),
        .full       (q_full),
        .count      (q_count)
    );

    jsesc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (q_head_valid),
        .head_job   (q_head_job),
        .pop        (q_pop),
        .out_valid  (out_valid),
        .out_char   (out_char),
        .end_of_run (end_of_run),
        .out_stall  (out_stall)
    );

    // Buffered bytes never outrun what the lead byte asked for
    `JSESC_CHECK_NOW(a_pend_within_need, 1'b1, front_stat.pend_cnt <= front_stat.need_cnt, "pending count exceeds needed count")
    // A lead is buffered exactly when a sequence is open
    `JSESC_CHECK_NOW(a_pend_need_pair, 1'b1, (front_stat.pend_cnt == 2'd0) == (front_stat.need_cnt == 2'd0), "pending and needed counts disagree")
    // Queued work reaches the output on the next cycle when not stalled
    `JSESC_CHECK_NEXT(a_queue_drains, (q_count != 2'd0) && !out_stall, out_valid, "queued job did not produce output")

endmodule

`default_nettype wire
